// ===== rtl/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg: shared types for the move-toward-target block
// Payload structs for both channels and the configuration register indexes.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int RATE_FRAC_BITS = 16;
  localparam logic [31:0] SIGN32 = 32'h8000_0000;

  typedef enum logic [1:0] {
    CFG_TARGET_X = 2'd0,
    CFG_TARGET_Y = 2'd1,
    CFG_TARGET_Z = 2'd2,
    CFG_SPEED    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [23:0] timestep;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic               reached;
  } out_t;

endpackage

// ===== rtl/move_toward_target_3d.sv =====
// ----------------------------------------------------------------------------
// move_toward_target_3d: pipelined step of a 3D point toward a target
// Moves each position by speed times timestep toward the configured target,
// landing on the target when it is within reach.
// The block accepts one position per clock while the output side does not
// stall and returns one result per transfer, in order. The pipeline is made
// of four front stages (differences, squares, the squared distance and the
// reach test), a 33-stage digit-by-digit square root of the squared distance,
// one stage that loads the divider and a 32-stage restoring divider, one
// quotient bit per stage for each axis. A stall on a valid output freezes the
// whole pipeline; the input stall follows the output stall in the same cycle.
// The configuration registers (target and speed) are always ready and should
// be written only while no transfer is in flight.
module move_toward_target_3d
  import mtt_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DISP_SHIFT = 2 * RATE_FRAC_BITS - COORD_FRAC_BITS;
  localparam int NSQ = 33;
  localparam int NDV = 32;

  // Per-item data that rides along the whole pipeline.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic             reached;
  } carry_t;

  typedef struct packed {
    logic             v;
    carry_t           c;
    logic [65:0]      rad;
    logic [35:0]      rem;
    logic [32:0]      root;
    logic [2:0][65:0] dm;
  } sq_t;

  typedef struct packed {
    logic             v;
    carry_t           c;
    logic [32:0]      len;
    logic [2:0][33:0] rem;
    logic [2:0][31:0] low;
    logic [2:0][31:0] q;
  } dv_t;

  logic [2:0][31:0] target;
  logic [23:0]      speed;

  // Early stages: differences, products, squared distance and reach test.
  logic             v1, v2, v3;
  logic [2:0][31:0] pos1, pos2, pos3;
  logic [2:0]       neg1, neg2, neg3;
  logic [2:0][31:0] mag1, mag2, mag3;
  logic [47:0]      st1;
  logic [2:0][63:0] sqr2;
  logic [33:0]      disp2, disp3;
  logic             big2, big3;
  logic [65:0]      ssum3;
  logic [67:0]      dd3;

  sq_t sq [0:NSQ];
  sq_t sq_next [1:NSQ];
  dv_t dv [0:NDV];
  dv_t dv_next [0:NDV];

  logic en;
  logic [2:0][31:0] pin;
  logic [2:0][31:0] mag_in;
  logic [2:0]       neg_in;
  logic [47:0]      dsh;
  logic [2:0][31:0] step;
  logic [2:0][31:0] new_pos;

  // The pipeline moves whenever the output register is free or being taken.
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = dv[NDV].v;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      speed  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET_X: target[0] <= cfg_data;
        CFG_TARGET_Y: target[1] <= cfg_data;
        CFG_TARGET_Z: target[2] <= cfg_data;
        CFG_SPEED:    speed     <= cfg_data[23:0];
        default:      speed     <= speed;
      endcase
    end
  end

  // Per-axis magnitude of the difference, computed in offset binary so that
  // an unsigned compare orders the signed coordinates.
  always_comb begin
    pin[0] = in_data.pos_x;
    pin[1] = in_data.pos_y;
    pin[2] = in_data.pos_z;
    for (int i = 0; i < 3; i++) begin
      if ((target[i] ^ SIGN32) >= (pin[i] ^ SIGN32)) begin
        mag_in[i] = (target[i] ^ SIGN32) - (pin[i] ^ SIGN32);
        neg_in[i] = 1'b0;
      end else begin
        mag_in[i] = (pin[i] ^ SIGN32) - (target[i] ^ SIGN32);
        neg_in[i] = 1'b1;
      end
    end
    dsh = st1 >> DISP_SHIFT;
  end

  // Square root stages: each one brings down two bits of the squared
  // distance and decides one bit of the root.
  always_comb begin
    logic [35:0] r;
    logic [35:0] t;
    for (int j = 1; j <= NSQ; j++) begin
      sq_next[j] = sq[j-1];
      r = {sq[j-1].rem[33:0], sq[j-1].rad[65:64]};
      t = {1'b0, sq[j-1].root, 2'b01};
      sq_next[j].rad = {sq[j-1].rad[63:0], 2'b00};
      if (r >= t) begin
        sq_next[j].rem  = r - t;
        sq_next[j].root = {sq[j-1].root[31:0], 1'b1};
      end else begin
        sq_next[j].rem  = r;
        sq_next[j].root = {sq[j-1].root[31:0], 1'b0};
      end
    end
  end

  // Divider stages: displacement times magnitude over the distance, one
  // quotient bit per stage for each axis. When the point is not within reach
  // the quotient does not exceed the magnitude, so the upper half of the dividend starts below the divisor.
  always_comb begin
    logic [33:0] r;
    dv_next[0].v   = sq[NSQ].v;
    dv_next[0].c   = sq[NSQ].c;
    dv_next[0].len = sq[NSQ].root;
    for (int i = 0; i < 3; i++) begin
      dv_next[0].rem[i] = sq[NSQ].dm[i][65:32];
      dv_next[0].low[i] = sq[NSQ].dm[i][31:0];
      dv_next[0].q[i]   = '0;
    end
    for (int j = 1; j <= NDV; j++) begin
      dv_next[j] = dv[j-1];
      for (int i = 0; i < 3; i++) begin
        r = {dv[j-1].rem[i][32:0], dv[j-1].low[i][31]};
        dv_next[j].low[i] = {dv[j-1].low[i][30:0], 1'b0};
        if (r >= {1'b0, dv[j-1].len}) begin
          dv_next[j].rem[i] = r - {1'b0, dv[j-1].len};
          dv_next[j].q[i]   = {dv[j-1].q[i][30:0], 1'b1};
        end else begin
          dv_next[j].rem[i] = r;
          dv_next[j].q[i]   = {dv[j-1].q[i][30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int j = 0; j <= NSQ; j++) sq[j].v <= 1'b0;
      for (int j = 0; j <= NDV; j++) dv[j].v <= 1'b0;
    end else if (en) begin
      // Stage 1: magnitudes and the raw speed-times-timestep product.
      v1   <= in_valid;
      pos1 <= pin;
      neg1 <= neg_in;
      mag1 <= mag_in;
      st1  <= speed * in_data.timestep;
      // Stage 2: squares per axis and the scaled displacement.
      v2   <= v1;
      pos2 <= pos1;
      neg2 <= neg1;
      mag2 <= mag1;
      for (int i = 0; i < 3; i++) sqr2[i] <= 64'(mag1[i]) * 64'(mag1[i]);
      disp2 <= dsh[33:0];
      big2  <= |dsh[47:34];
      // Stage 3: squared distance and squared displacement.
      v3    <= v2;
      pos3  <= pos2;
      neg3  <= neg2;
      mag3  <= mag2;
      ssum3 <= 66'(sqr2[0]) + 66'(sqr2[1]) + 66'(sqr2[2]);
      dd3   <= 68'(disp2) * 68'(disp2);
      disp3 <= disp2;
      big3  <= big2;
      // Stage 4: reach decision and the dividends for the advance.
      sq[0].v         <= v3;
      sq[0].c.pos     <= pos3;
      sq[0].c.neg     <= neg3;
      sq[0].c.mag     <= mag3;
      sq[0].c.reached <= big3 || (dd3 >= {2'b00, ssum3});
      sq[0].rad       <= ssum3;
      sq[0].rem       <= '0;
      sq[0].root      <= '0;
      for (int i = 0; i < 3; i++) sq[0].dm[i] <= 66'(disp3) * 66'(mag3[i]);
      for (int j = 1; j <= NSQ; j++) sq[j] <= sq_next[j];
      for (int j = 0; j <= NDV; j++) dv[j] <= dv_next[j];
    end
  end

  // Output: clamp the step to the magnitude and move toward the target,
  // or land on the target when it is within reach.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      step[i] = (dv[NDV].q[i] > dv[NDV].c.mag[i]) ? dv[NDV].c.mag[i] : dv[NDV].q[i];
      if (dv[NDV].c.reached) begin
        new_pos[i] = target[i];
      end else if (dv[NDV].c.neg[i]) begin
        new_pos[i] = dv[NDV].c.pos[i] - step[i];
      end else begin
        new_pos[i] = dv[NDV].c.pos[i] + step[i];
      end
    end
    out_data.new_x   = new_pos[0];
    out_data.new_y   = new_pos[1];
    out_data.new_z   = new_pos[2];
    out_data.reached = dv[NDV].c.reached;
  end

endmodule

// ===== test/move_toward_target_3d_test.sv =====
// ----------------------------------------------------------------------------
// move_toward_target_3d_test: self-checking bench for the target-seeking step
// Drives positions through the pipeline under random idling on both sides,
// predicts each moved point in exact integer arithmetic and compares the
// results field by field, in order, against the transfers that come out.
// ----------------------------------------------------------------------------
module move_toward_target_3d_test;
  import mtt_pkg::*;

  localparam int FRAC = 16;
  // The drain pause leaves a margin over the pipeline latency.
  localparam int DRAIN_CYCLES = 120;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_TARGET_X;
  logic [31:0] cfg_data = '0;

  // Bench copy of the configuration registers.
  logic [31:0] target_reg [3];
  logic [23:0] speed_reg;

  out_t pending_moves [$];
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   failed = 1'b0;

  move_toward_target_3d #(.COORD_FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Computes where the point lands. Coordinates are turned into offset
  // binary so that unsigned order matches signed order; the squared
  // distance and the reach test are exact, the step is floor(D*|d|/L) with
  // L the integer square root of the squared distance.
  function automatic out_t predict_move(in_t item);
    logic [31:0]  pos [3];
    logic [31:0]  pb, tb, nb;
    logic [31:0]  mag [3];
    bit           neg [3];
    logic [31:0]  moved [3];
    logic [47:0]  prod;
    logic [127:0] disp, dist_sq, root, trial, step;
    out_t         res;
    pos[0] = item.pos_x;
    pos[1] = item.pos_y;
    pos[2] = item.pos_z;
    prod = speed_reg * item.timestep;
    disp = prod >> (2 * RATE_FRAC_BITS - FRAC);
    dist_sq = '0;
    for (int i = 0; i < 3; i++) begin
      pb = pos[i] ^ SIGN32;
      tb = target_reg[i] ^ SIGN32;
      neg[i] = (tb < pb);
      mag[i] = neg[i] ? pb - tb : tb - pb;
      dist_sq = dist_sq + 128'(mag[i]) * 128'(mag[i]);
    end
    if (disp * disp >= dist_sq) begin
      res.new_x = target_reg[0];
      res.new_y = target_reg[1];
      res.new_z = target_reg[2];
      res.reached = 1'b1;
    end else begin
      root = '0;
      for (int b = 34; b >= 0; b--) begin
        trial = root | (128'd1 << b);
        if (trial * trial <= dist_sq) root = trial;
      end
      if (root == 0) root = 1;
      for (int i = 0; i < 3; i++) begin
        step = (disp * 128'(mag[i])) / root;
        if (step > 128'(mag[i])) step = 128'(mag[i]);
        pb = pos[i] ^ SIGN32;
        nb = neg[i] ? pb - step[31:0] : pb + step[31:0];
        moved[i] = nb ^ SIGN32;
      end
      res.new_x = moved[0];
      res.new_y = moved[1];
      res.new_z = moved[2];
      res.reached = 1'b0;
    end
    return res;
  endfunction

  // The receiver decides each cycle whether to hold off the output.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Every output transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_moves.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        failed = 1'b1;
      end else begin
        want = pending_moves.pop_front();
        if (out_data.new_x !== want.new_x) begin
          $display("%0t: new_x expected %h actual %h", $time, want.new_x, out_data.new_x);
          failed = 1'b1;
        end
        if (out_data.new_y !== want.new_y) begin
          $display("%0t: new_y expected %h actual %h", $time, want.new_y, out_data.new_y);
          failed = 1'b1;
        end
        if (out_data.new_z !== want.new_z) begin
          $display("%0t: new_z expected %h actual %h", $time, want.new_z, out_data.new_z);
          failed = 1'b1;
        end
        if (out_data.reached !== want.reached) begin
          $display("%0t: reached expected %b actual %b", $time, want.reached,
                   out_data.reached);
          failed = 1'b1;
        end
      end
    end
  end

  // Sends one position; the sender may first idle at random.
  // The prediction is queued at the edge where the transfer happens.
  task automatic send_position(input in_t item);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (in_stall);
    pending_moves.push_back(predict_move(item));
  endtask

  // Lets the pipeline empty before the configuration is touched.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_moves.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SPEED) speed_reg = value[23:0];
    else target_reg[idx] = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_motion(input logic [31:0] tx, ty, tz, input logic [23:0] spd);
    drain_pipeline();
    write_register(CFG_TARGET_X, tx);
    write_register(CFG_TARGET_Y, ty);
    write_register(CFG_TARGET_Z, tz);
    write_register(CFG_SPEED, {8'd0, spd});
  endtask

  function automatic in_t make_item(logic [31:0] x, y, z, logic [23:0] ts);
    in_t item;
    item.pos_x = x;
    item.pos_y = y;
    item.pos_z = z;
    item.timestep = ts;
    return item;
  endfunction

  // With the reset configuration the speed is zero, so only a position
  // at the origin counts as reached.
  task automatic test_reset_config();
    send_position(make_item(32'd0, 32'd0, 32'd0, 24'hFF_FFFF));
    send_position(make_item(32'h0001_0000, 32'd0, 32'hFFFF_0000, 24'hFF_FFFF));
  endtask

  // Coordinate and rate extremes, including the far corners of the space.
  task automatic test_extremes();
    set_motion(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_position(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF));
    send_position(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'd1));
    send_position(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 24'h01_0000));
    set_motion(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 24'd1);
    send_position(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF));
    send_position(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 24'hFF_FFFF));
    send_position(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd0));
  endtask

  // Zero distance, zero speed or timestep, and the exact reach boundary.
  task automatic test_special_cases();
    // Speed 1.0 and a 5 s step give a displacement of exactly five units.
    set_motion(32'h0010_0000, 32'hFFF0_0000, 32'h0000_1234, 24'h01_0000);
    send_position(make_item(32'h0010_0000, 32'hFFF0_0000, 32'h0000_1234, 24'd0));
    send_position(make_item(32'h0010_0000, 32'hFFF0_0000, 32'h0000_1234, 24'h05_0000));
    send_position(make_item(32'h0010_0000 - 32'h0005_0000, 32'hFFF0_0000, 32'h0000_1234,
                            24'h05_0000));
    send_position(make_item(32'h0010_0000 - 32'h0005_0001, 32'hFFF0_0000, 32'h0000_1234,
                            24'h05_0000));
    send_position(make_item(32'h0010_0000 + 32'h0003_0000, 32'hFFF0_0000 - 32'h0004_0000,
                            32'h0000_1234, 24'h05_0000));
    send_position(make_item(32'h0010_0000 + 32'h0003_0000, 32'hFFF0_0000 - 32'h0004_0001,
                            32'h0000_1234, 24'h05_0000));
    send_position(make_item(32'h1234_5678, 32'hEDCB_A987, 32'h0000_0000, 24'h00_0001));
    set_motion(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 24'd0);
    send_position(make_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF));
    send_position(make_item(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF));
  endtask

  function automatic logic [31:0] near(logic [31:0] centre);
    int span;
    span = 1 << $urandom_range(24, 4);
    return centre + $urandom_range(span) - span / 2;
  endfunction

  // Random motion: most positions sit near the target so that both the
  // reached and the advancing outcomes are common; the rest are anywhere.
  task automatic test_random_motion(input int count);
    in_t item;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 70) begin
        item.pos_x = near(target_reg[0]);
        item.pos_y = near(target_reg[1]);
        item.pos_z = near(target_reg[2]);
      end else begin
        item.pos_x = $urandom;
        item.pos_y = $urandom;
        item.pos_z = $urandom;
      end
      case ($urandom_range(3))
        0: item.timestep = $urandom_range(24'hFF_FFFF);
        1: item.timestep = $urandom_range(24'h00_FFFF);
        2: item.timestep = $urandom_range(24'h00_0FFF);
        default: item.timestep = 24'd1 << $urandom_range(23);
      endcase
      send_position(item);
    end
  endtask

  task automatic test_random_phase(input int sender_pct, receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int k = 0; k < 4; k++) begin
      set_motion($urandom, $urandom, $urandom,
                 (k == 3) ? 24'hFF_FFFF : 24'($urandom_range(24'h3F_FFFF)));
      test_random_motion(70);
    end
  endtask

  initial begin
    target_reg[0] = '0;
    target_reg[1] = '0;
    target_reg[2] = '0;
    speed_reg = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_config();
    test_extremes();
    test_special_cases();
    test_random_phase(15, 58);
    test_random_phase(58, 15);
    test_random_phase(0, 0);
    drain_pipeline();
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
